### rtl/core/rgp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_pkg
// Shared types, constants and helpers of the row grid placer.
// ----------------------------------------------------------------------------
package rgp_pkg;

    // Upper bound on the copies of one part
    localparam logic [6:0] COPY_MAX = 7'd64;

    // Register map codes, paddr[3:2]
    localparam logic [1:0] REG_COLUMN_LIMIT    = 2'd0;
    localparam logic [1:0] REG_GAP_HORIZONTAL  = 2'd1;
    localparam logic [1:0] REG_GAP_VERTICAL    = 2'd2;
    localparam logic [1:0] REG_ROW_WIDTH_LIMIT = 2'd3;

    // 40-bit position range, held in 42-bit arithmetic
    localparam logic signed [41:0] POS_MAX_W = 42'sd549755813887;
    localparam logic signed [41:0] POS_MIN_W = -42'sd549755813888;
    localparam logic signed [39:0] POS_MAX   = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] POS_MIN   = 40'sh80_0000_0000;

    // Configuration register set
    typedef struct packed {
        logic        [15:0] column_limit;
        logic signed [31:0] gap_horizontal;
        logic signed [31:0] gap_vertical;
        logic        [30:0] row_width_limit;
    } rgp_cfg_t;

    // One finished part, front to back
    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic        [6:0]  copies;
        logic               restart;
    } rgp_part_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT,
        ST_WRAP
    } rgp_state_t;

    // Clamp a 42-bit signed value into the 40-bit position range
    function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
        logic signed [39:0] r;
        begin
            if (v > POS_MAX_W)
                r = POS_MAX;
            else if (v < POS_MIN_W)
                r = POS_MIN;
            else
                r = v[39:0];
            return r;
        end
    endfunction

endpackage

### rtl/core/rgp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_front
// Vertex intake: tracks the bounding box of the current part and builds
// the part record on its last vertex.
// ----------------------------------------------------------------------------
module rgp_front
    import rgp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic signed [31:0] vertex_x,
    input  logic signed [31:0] vertex_y,
    input  logic               last_vertex,
    input  logic        [6:0]  copy_count,
    input  logic               job_start,
    output rgp_part_t          part
);

    logic signed [31:0] min_x_reg, min_x_next;
    logic signed [31:0] min_y_reg, min_y_next;
    logic signed [31:0] max_x_reg, max_x_next;
    logic signed [31:0] max_y_reg, max_y_next;
    logic               pending_reg, pending_next;
    logic               start_seen_reg, start_seen_next;
    logic               open_box;
    logic        [6:0]  copies;

    assign open_box = pending_reg | job_start;

    always_comb
    begin
        if (open_box)
        begin
            min_x_next = vertex_x;
            max_x_next = vertex_x;
            min_y_next = vertex_y;
            max_y_next = vertex_y;
        end
        else
        begin
            min_x_next = (vertex_x < min_x_reg) ? vertex_x : min_x_reg;
            max_x_next = (vertex_x > max_x_reg) ? vertex_x : max_x_reg;
            min_y_next = (vertex_y < min_y_reg) ? vertex_y : min_y_reg;
            max_y_next = (vertex_y > max_y_reg) ? vertex_y : max_y_reg;
        end

        if (copy_count == 7'd0)
            copies = 7'd1;
        else if (copy_count > COPY_MAX)
            copies = COPY_MAX;
        else
            copies = copy_count;

        pending_next    = last_vertex;
        start_seen_next = last_vertex ? 1'b0 : (start_seen_reg | job_start);
    end

    assign part.min_x   = min_x_next;
    assign part.min_y   = min_y_next;
    assign part.max_x   = max_x_next;
    assign part.max_y   = max_y_next;
    assign part.copies  = copies;
    assign part.restart = start_seen_reg | job_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 1'b1;
            start_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg    <= pending_next;
            start_seen_reg <= start_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            min_x_reg <= min_x_next;
            min_y_reg <= min_y_next;
            max_x_reg <= max_x_next;
            max_y_reg <= max_y_next;
        end
    end

endmodule

### rtl/core/rgp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_queue
// Short part queue between intake and placement.
// ----------------------------------------------------------------------------
module rgp_queue
    import rgp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  rgp_part_t push_data,
    input  logic      pop,
    output rgp_part_t pop_data,
    output logic      empty,
    output logic      full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rgp_part_t          slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign empty    = (count_reg == CNT_W'(0));
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign pop_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/core/rgp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_back
// Placement sequencer: walks the copies of one part, moves the cursor along
// rows and drives the registered result port.
// ----------------------------------------------------------------------------
module rgp_back
    import rgp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  rgp_cfg_t     cfg,
    input  rgp_part_t    part,
    input  logic         part_empty,
    output logic         part_pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,
    output logic         m_tlast
);

    rgp_state_t         state_reg, state_next;
    logic signed [39:0] cx_reg, cx_next;
    logic signed [39:0] cy_reg, cy_next;
    logic        [32:0] rh_reg, rh_next;
    logic        [15:0] col_reg, col_next;
    logic        [6:0]  left_reg, left_next;
    logic               to_emit_reg, to_emit_next;
    logic signed [31:0] bmin_x_reg, bmin_y_reg;
    logic        [32:0] w_reg, h_reg;
    logic signed [39:0] out_x_reg, out_y_reg;
    logic               out_last_reg;
    logic               out_valid_reg, out_valid_next;

    logic               width_mode;
    logic        [15:0] limit;
    logic               emit_fire;
    logic signed [41:0] cx_ext, cy_ext, w_ext, rh_ext;
    logic signed [41:0] reach_x, step_x, step_y, rwl_ext;
    logic signed [41:0] diff_x, diff_y;
    logic        [15:0] col_inc;
    logic        [32:0] rh_max;
    logic        [32:0] w_load, h_load;

    assign width_mode = (cfg.row_width_limit != 31'd0);
    assign limit      = (cfg.column_limit == 16'd0) ? 16'd1 : cfg.column_limit;
    assign part_pop   = (state_reg == ST_IDLE) && !part_empty;
    assign emit_fire  = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    assign cx_ext  = {{2{cx_reg[39]}}, cx_reg};
    assign cy_ext  = {{2{cy_reg[39]}}, cy_reg};
    assign w_ext   = {9'd0, w_reg};
    assign rh_ext  = {9'd0, rh_reg};
    assign rwl_ext = {11'd0, cfg.row_width_limit};
    assign reach_x = cx_ext + w_ext;
    assign step_x  = cx_ext + w_ext + {{10{cfg.gap_horizontal[31]}}, cfg.gap_horizontal};
    assign step_y  = cy_ext + rh_ext + {{10{cfg.gap_vertical[31]}}, cfg.gap_vertical};
    assign diff_x  = cx_ext - {{10{bmin_x_reg[31]}}, bmin_x_reg};
    assign diff_y  = cy_ext - {{10{bmin_y_reg[31]}}, bmin_y_reg};
    assign col_inc = (col_reg == 16'hFFFF) ? col_reg : col_reg + 16'd1;
    assign rh_max  = (h_reg > rh_reg) ? h_reg : rh_reg;
    assign w_load  = {part.max_x[31], part.max_x} - {part.min_x[31], part.min_x};
    assign h_load  = {part.max_y[31], part.max_y} - {part.min_y[31], part.min_y};

    always_comb
    begin
        state_next     = state_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        rh_next        = rh_reg;
        col_next       = col_reg;
        left_next      = left_reg;
        to_emit_next   = to_emit_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        if (emit_fire)
            out_valid_next = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (!part_empty)
                begin
                    left_next  = part.copies;
                    state_next = ST_CHECK;
                    if (part.restart)
                    begin
                        cx_next  = '0;
                        cy_next  = '0;
                        rh_next  = '0;
                        col_next = '0;
                    end
                end
            end
            ST_CHECK:
            begin
                // wrap before a copy that would overflow the row
                if (width_mode && col_reg != 16'd0 && reach_x > rwl_ext)
                begin
                    to_emit_next = 1'b1;
                    state_next   = ST_WRAP;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    cx_next   = sat40(step_x);
                    rh_next   = rh_max;
                    col_next  = col_inc;
                    left_next = left_reg - 7'd1;
                    if (!width_mode && col_inc >= limit)
                    begin
                        to_emit_next = 1'b0;
                        state_next   = ST_WRAP;
                    end
                    else if (left_reg == 7'd1)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_WRAP:
            begin
                cx_next  = '0;
                cy_next  = sat40(step_y);
                rh_next  = '0;
                col_next = '0;
                if (to_emit_reg)
                    state_next = ST_EMIT;
                else if (left_reg == 7'd0)
                    state_next = ST_IDLE;
                else
                    state_next = ST_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cx_reg        <= '0;
            cy_reg        <= '0;
            rh_reg        <= '0;
            col_reg       <= '0;
            left_reg      <= '0;
            to_emit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            rh_reg        <= rh_next;
            col_reg       <= col_next;
            left_reg      <= left_next;
            to_emit_reg   <= to_emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (part_pop)
        begin
            bmin_x_reg <= part.min_x;
            bmin_y_reg <= part.min_y;
            w_reg      <= w_load;
            h_reg      <= h_load;
        end
        if (emit_fire)
        begin
            out_x_reg    <= sat40(diff_x);
            out_y_reg    <= sat40(diff_y);
            out_last_reg <= (left_reg == 7'd1);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;

    a_check_has_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK || state_reg == ST_EMIT) |-> left_reg != 7'd0)
        else $error("placement step with no copy left");

    a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRAP |=> (cx_reg == 40'sd0 && col_reg == 16'd0 && rh_reg == 33'd0))
        else $error("row wrap did not clear the row");

    a_last_ends_part: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && left_reg == 7'd1)
            |=> (state_reg == ST_IDLE || state_reg == ST_WRAP) && m_tlast)
        else $error("final copy did not close the part");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        part_pop |=> state_reg == ST_CHECK)
        else $error("part load did not start placement");

endmodule

### rtl/core/row_grid_placer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_grid_placer
// Row-by-row grid placement of part bounding boxes from an outline stream.
// ----------------------------------------------------------------------------
// Path: the first copy of a part reaches m_tvalid from its last vertex
//   transaction through queue write, part load, row check, result register.
// Throughput: vertices enter at 1 per cycle while the part queue has room;
//   the placement sequencer takes a load state per part, a check and an emit
//   state per copy and a wrap state on each row wrap; emits can wait on m_tready.
// Reset (rst_n low, asynchronous): cursor, row, queue and handshakes clear,
//   registers take their reset values; no clearing pass.
// ----------------------------------------------------------------------------
module row_grid_placer
    import rgp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // vertex stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // vertex_x[31:0], vertex_y[63:32], copy_count[70:64], 0
    input  logic         s_tlast,   // last_vertex
    input  logic         s_tuser,   // job_start
    // placement stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // offset_x[39:0], offset_y[79:40]
    output logic         m_tlast    // last_copy
);

    rgp_cfg_t   cfg_reg;
    logic       cfg_write;
    logic       in_fire;
    logic       q_push;
    logic       q_pop;
    logic       q_empty;
    logic       q_full;
    rgp_part_t  front_part;
    rgp_part_t  back_part;

    // ------------------------------------------------------------------
    // Configuration registers. Writes land on the access phase; software
    // must write only while idle, not enforced: the sequencer reads them live.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.column_limit    <= 16'd1;
            cfg_reg.gap_horizontal  <= '0;
            cfg_reg.gap_vertical    <= '0;
            cfg_reg.row_width_limit <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_COLUMN_LIMIT:    cfg_reg.column_limit    <= pwdata[15:0];
                REG_GAP_HORIZONTAL:  cfg_reg.gap_horizontal  <= pwdata;
                REG_GAP_VERTICAL:    cfg_reg.gap_vertical    <= pwdata;
                REG_ROW_WIDTH_LIMIT: cfg_reg.row_width_limit <= pwdata[30:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Read back the selected register, zero-extended to the bus
    always_comb
    begin
        case (paddr[3:2])
            REG_COLUMN_LIMIT:    prdata = {16'd0, cfg_reg.column_limit};
            REG_GAP_HORIZONTAL:  prdata = cfg_reg.gap_horizontal;
            REG_GAP_VERTICAL:    prdata = cfg_reg.gap_vertical;
            REG_ROW_WIDTH_LIMIT: prdata = {1'b0, cfg_reg.row_width_limit};
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front: take a vertex transaction whenever the part queue can hold one
    // more part, so an accepted last vertex always finds a free queue slot.
    // ------------------------------------------------------------------
    assign s_tready = ~q_full;
    assign in_fire  = s_tvalid & s_tready;
    assign q_push   = in_fire & s_tlast;

    rgp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_fire),
        .vertex_x    (s_tdata[31:0]),
        .vertex_y    (s_tdata[63:32]),
        .last_vertex (s_tlast),
        .copy_count  (s_tdata[70:64]),
        .job_start   (s_tuser),
        .part        (front_part)
    );

    // ------------------------------------------------------------------
    // Part queue: decouples intake from copy emission. A job start travels
    // with the next part so the cursor clears just before that part places.
    // ------------------------------------------------------------------
    rgp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_part),
        .pop       (q_pop),
        .pop_data  (back_part),
        .empty     (q_empty),
        .full      (q_full)
    );

    // ------------------------------------------------------------------
    // Back: per copy, check the row fit, emit the translation into the
    // output register, advance the cursor, wrap the row as needed.
    // ------------------------------------------------------------------
    rgp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .part       (back_part),
        .part_empty (q_empty),
        .part_pop   (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
